/* rtl/core/sbfp_pkg.sv */
`timescale 1ns / 1ps

package sbfp_pkg;

  localparam int unsigned MaxParams  = 32;
  localparam int unsigned IdxW       = (MaxParams > 1) ? $clog2(MaxParams) : 1;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned ParamIdxW  = 5;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  localparam logic [ByteW-1:0] SyncByte = 8'hFF;
  localparam logic [ByteW-1:0] ErrMax   = 8'hFF;

  typedef enum logic [StatusW-1:0] {
    ST_GOOD = 2'd0,
    ST_SYNC = 2'd1,
    ST_CSUM = 2'd2,
    ST_OVER = 2'd3
  } status_e;

  // one finished frame or error, handed from the front to the back
  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] device_id;
    logic [ByteW-1:0] instruction;
    logic [ByteW-1:0] param_count;
    logic [ByteW-1:0] error_count;
  } desc_t;

  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  addr;
    logic [ByteW-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
  } store_rd_t;

endpackage

/* rtl/core/sbfp_in_if.sv */
`timescale 1ns / 1ps

interface sbfp_in_if;
  import sbfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/sbfp_out_if.sv */
`timescale 1ns / 1ps

interface sbfp_out_if;
  import sbfp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic [ByteW-1:0]     device_id;
  logic [ByteW-1:0]     instruction;
  logic [ByteW-1:0]     param_count;
  logic                 has_param;
  logic [ParamIdxW-1:0] param_index;
  logic [ByteW-1:0]     param_byte;
  logic [ByteW-1:0]     error_count;
  logic                 last;

  modport source (
    output valid, output status, output device_id, output instruction,
    output param_count, output has_param, output param_index, output param_byte,
    output error_count, output last, input ready
  );
  modport sink (
    input valid, input status, input device_id, input instruction,
    input param_count, input has_param, input param_index, input param_byte,
    input error_count, input last, output ready
  );
endinterface

/* rtl/core/sbfp_param_store.sv */
`timescale 1ns / 1ps

module sbfp_param_store (
  input  logic                     clk_i,
  input  sbfp_pkg::store_wr_t      wr_i,
  input  sbfp_pkg::store_rd_t      rd_i,
  output logic [sbfp_pkg::ByteW-1:0] rdata_o
);
  import sbfp_pkg::*;

  logic [ByteW-1:0] mem [MaxParams];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sbfp_front.sv */
`timescale 1ns / 1ps

module sbfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sbfp_in_if.sink             in_i,
  input  logic                store_busy_i,
  input  logic                push_ready_i,
  output logic                push_valid_o,
  output sbfp_pkg::desc_t     push_desc_o,
  output sbfp_pkg::store_wr_t store_wr_o
);
  import sbfp_pkg::*;

  typedef enum logic [6:0] {
    PH_SYNC1 = 7'b0000001,
    PH_SYNC2 = 7'b0000010,
    PH_ID    = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_INSTR = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_CSUM  = 7'b1000000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] id_q, id_d;
  logic [ByteW-1:0] instr_q, instr_d;
  logic [ByteW-1:0] expected_q, expected_d;
  logic [ByteW-1:0] seen_q, seen_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] errs_q, errs_d;

  logic             acc;
  logic [ByteW-1:0] rx;
  logic [ByteW-1:0] err_inc;
  logic [ByteW-1:0] want;
  logic [ByteW-1:0] sum_add;

  always_comb begin
    case (phase_q)
      PH_SYNC1, PH_SYNC2, PH_CSUM: in_i.ready = push_ready_i;
      PH_DATA:                     in_i.ready = !store_busy_i;
      default:                     in_i.ready = 1'b1;
    endcase
  end

  assign acc     = in_i.valid && in_i.ready;
  assign rx      = in_i.rx_byte;
  assign err_inc = (errs_q != ErrMax) ? errs_q + 8'd1 : errs_q;
  assign want    = ~sum_q;
  assign sum_add = sum_q + rx;

  always_comb begin
    phase_d      = phase_q;
    id_d         = id_q;
    instr_d      = instr_q;
    expected_d   = expected_q;
    seen_d       = seen_q;
    sum_d        = sum_q;
    errs_d       = errs_q;
    push_valid_o = 1'b0;
    push_desc_o  = '{status: ST_SYNC, device_id: '0, instruction: '0,
                     param_count: '0, error_count: err_inc};
    store_wr_o   = '{en: 1'b0, addr: seen_q[IdxW-1:0], data: rx};
    if (acc) begin
      case (phase_q)
        PH_SYNC1, PH_SYNC2: begin
          if (rx != SyncByte) begin
            errs_d       = err_inc;
            phase_d      = PH_SYNC1;
            push_valid_o = 1'b1;
          end else begin
            id_d       = '0;
            instr_d    = '0;
            expected_d = '0;
            seen_d     = '0;
            sum_d      = '0;
            phase_d    = (phase_q == PH_SYNC1) ? PH_SYNC2 : PH_ID;
          end
        end
        PH_ID: begin
          id_d    = rx;
          sum_d   = sum_add;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          expected_d = (rx >= 8'd2) ? rx - 8'd2 : '0;
          sum_d      = sum_add;
          phase_d    = PH_INSTR;
        end
        PH_INSTR: begin
          instr_d = rx;
          sum_d   = sum_add;
          phase_d = (expected_q != '0) ? PH_DATA : PH_CSUM;
        end
        PH_DATA: begin
          sum_d         = sum_add;
          store_wr_o.en = (32'(seen_q) < MaxParams);
          seen_d        = seen_q + 8'd1;
          if (seen_d >= expected_q) begin
            phase_d = PH_CSUM;
          end
        end
        PH_CSUM: begin
          phase_d                  = PH_SYNC1;
          push_valid_o             = 1'b1;
          push_desc_o.device_id    = id_q;
          push_desc_o.instruction  = instr_q;
          push_desc_o.param_count  = expected_q;
          if (32'(expected_q) > MaxParams) begin
            errs_d             = err_inc;
            push_desc_o.status = ST_OVER;
          end else if (rx != want) begin
            errs_d             = err_inc;
            push_desc_o.status = ST_CSUM;
          end else begin
            errs_d                  = '0;
            push_desc_o.status      = ST_GOOD;
            push_desc_o.error_count = '0;
          end
        end
        default: phase_d = PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SYNC1;
      id_q       <= '0;
      instr_q    <= '0;
      expected_q <= '0;
      seen_q     <= '0;
      sum_q      <= '0;
      errs_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      id_q       <= id_d;
      instr_q    <= instr_d;
      expected_q <= expected_d;
      seen_q     <= seen_d;
      sum_q      <= sum_d;
      errs_q     <= errs_d;
    end
  end

endmodule

/* rtl/core/sbfp_queue.sv */
`timescale 1ns / 1ps

module sbfp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  sbfp_pkg::desc_t push_desc_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output sbfp_pkg::desc_t pop_desc_o,
  input  logic            pop_ready_i
);
  import sbfp_pkg::*;

  desc_t            entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             push, pop;

  assign push_ready_o = (32'(count_q) < QueueDepth);
  assign pop_valid_o  = (count_q != '0);
  assign pop_desc_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/sbfp_back.sv */
`timescale 1ns / 1ps

module sbfp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_valid_i,
  input  sbfp_pkg::desc_t            pop_desc_i,
  output logic                       pop_ready_o,
  output sbfp_pkg::store_rd_t        store_rd_o,
  input  logic [sbfp_pkg::ByteW-1:0] rdata_i,
  output logic                       busy_o,
  sbfp_out_if.source                 out_o
);
  import sbfp_pkg::*;

  logic            busy_q;
  desc_t           cur_q;
  logic [IdxW-1:0] idx_q;

  logic            ovalid_q;
  desc_t           res_q;
  logic            has_q;
  logic [IdxW-1:0] pidx_q;
  logic            last_q;

  logic            emit;
  logic            has_cur;
  logic            last_cur;

  assign pop_ready_o = !busy_q;
  assign busy_o      = busy_q;
  assign emit        = busy_q && (!ovalid_q || out_o.ready);
  assign has_cur     = (cur_q.status == ST_GOOD) && (cur_q.param_count != '0);
  assign last_cur    = !has_cur || (ByteW'(idx_q) == cur_q.param_count - 8'd1);

  assign store_rd_o  = '{en: emit && has_cur, addr: idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (!busy_q && pop_valid_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end
      if (emit) begin
        ovalid_q <= 1'b1;
        if (last_cur) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && pop_valid_i) begin
      cur_q <= pop_desc_i;
    end
    if (emit) begin
      res_q  <= cur_q;
      has_q  <= has_cur;
      pidx_q <= idx_q;
      last_q <= last_cur;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.status      = res_q.status;
  assign out_o.device_id   = res_q.device_id;
  assign out_o.instruction = res_q.instruction;
  assign out_o.param_count = res_q.param_count;
  assign out_o.has_param   = has_q;
  assign out_o.param_index = has_q ? ParamIdxW'(pidx_q) : '0;
  assign out_o.param_byte  = has_q ? rdata_i : '0;
  assign out_o.error_count = res_q.error_count;
  assign out_o.last        = last_q;

endmodule

/* rtl/core/servo_bus_frame_parser.sv */
`timescale 1ns / 1ps

// channel   modport  payload                                           request
// in_i      sink     rx_byte                                           one received byte
// out_o     source   status device_id instruction param_count          one frame or parameter result
//                    has_param param_index param_byte error_count last
//
// the front takes one byte per cycle; while the back is busy or a frame waits in the
// frame queue, a parameter byte of the next frame waits
// the back gives one result per cycle while out_o is ready, from a registered store read
// reset is asynchronous and active low; the parameter store is not cleared
// the front also waits at sync and checksum bytes when the two-entry frame queue is full

module servo_bus_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbfp_in_if.sink    in_i,
  sbfp_out_if.source out_o
);
  import sbfp_pkg::*;

  logic             push_valid, push_ready;
  desc_t            push_desc;
  logic             pop_valid, pop_ready;
  desc_t            pop_desc;
  store_wr_t        store_wr;
  store_rd_t        store_rd;
  logic [ByteW-1:0] rdata;
  logic             back_busy;
  logic             store_busy;

  assign store_busy = back_busy || pop_valid;

  sbfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .store_busy_i (store_busy),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_desc_o  (push_desc),
    .store_wr_o   (store_wr)
  );

  sbfp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_desc_i  (push_desc),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_desc_o   (pop_desc),
    .pop_ready_i  (pop_ready)
  );

  sbfp_param_store u_store (
    .clk_i   (clk_i),
    .wr_i    (store_wr),
    .rd_i    (store_rd),
    .rdata_o (rdata)
  );

  sbfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_desc_i  (pop_desc),
    .pop_ready_o (pop_ready),
    .store_rd_o  (store_rd),
    .rdata_i     (rdata),
    .busy_o      (back_busy),
    .out_o       (out_o)
  );

  a_store_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_wr.en |-> !back_busy && !pop_valid)
    else $error("parameter store written while a frame is draining");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != ST_GOOD) |-> out_o.last && !out_o.has_param)
    else $error("error result not a single final result");

  a_good_clears_errors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == ST_GOOD) |-> (out_o.error_count == '0))
    else $error("good frame with nonzero error count");

  a_read_follows_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_rd.en |=> out_o.valid && out_o.has_param)
    else $error("store read without a parameter result");

endmodule
